// File: design/dket_pkg.sv
// Shared types, codes and date helpers for the date-keyed entry table.
package dket_pkg;

	localparam int MAX_OUT = 64;
	localparam int NW = $clog2(MAX_OUT + 1);

	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_LIST = 2'd1;
	localparam logic [1:0] REQ_DEL  = 2'd2;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_MATCH   = 3'd3;
	localparam logic [2:0] ST_NOMATCH = 3'd4;
	localparam logic [2:0] ST_DELETED = 3'd5;

	// multiplicative inverse of 25 modulo 2^16, and the largest multiple test bound
	localparam logic [15:0] Inv25 = 16'd23593;
	localparam logic [15:0] Lim25 = 16'd2621;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
		logic [31:0] handle;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic wrap;
		logic load;
	} cell_ctl_t;

	function automatic logic div_by_25(input logic [15:0] y);
		logic [31:0] prod;
		begin
			prod = 32'(y) * 32'(Inv25);
			return prod[15:0] <= Lim25;
		end
	endfunction

	function automatic logic is_leap(input logic [15:0] y);
		logic d25;
		begin
			d25 = div_by_25(y);
			if (d25 && y[3:0] == 4'd0)
				return 1'b1;
			if (d25 && y[1:0] == 2'd0)
				return 1'b0;
			return y[1:0] == 2'd0;
		end
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		begin
			case (m)
				4'd2:                      n = leap ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
				default:                   n = 5'd31;
			endcase
			return n;
		end
	endfunction

	function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
			input logic [15:0] y);
		logic [4:0] lim;
		begin
			lim = month_days(m, is_leap(y));
			return (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= lim);
		end
	endfunction

endpackage

// File: design/dket_cell.sv
// One storage cell of the entry chain: holds an entry and takes its neighbor's.
module dket_cell import dket_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    nxt_e,
	input  entry_t    head_e,
	input  entry_t    load_e,
	output entry_t    ent
);

	entry_t e_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			e_q <= load_e;
		end else if (ctl.wrap) begin
			e_q <= head_e;
		end else if (ctl.shift) begin
			e_q <= nxt_e;
		end
	end

	assign ent = e_q;

endmodule

// File: design/date_keyed_entry_table.sv
// Top level of the date-keyed entry table: request sequencer and chain of entry cells.
//
// Requests come in on req_type/day/month/year/payload_handle with in_valid and
// in_stall; results leave on status/found_handle/last with out_valid and
// out_stall. A transfer happens on a clock edge with valid high and stall low.
// One request is worked at a time; in_stall is high from acceptance until the
// final result of that request has been loaded into the output register.
// Add: the request is registered, then checked and stored.
// List and delete: the entries sit in a row of cells, head at cell 0, and the
// occupied part rotates one place per cycle past the head comparator; a scan is
// registered, set up, run over every entry, then closed with a final result.
// List pauses the rotation while a match waits on a stalled output.
// Delete drops the first matching entry at the head and shrinks the ring, so
// the later entries close the gap during the same pass.
// Reset (arst_n low) empties the table and the output register; no clearing
// pass is needed because only cells below the entry count are ever read.
// A stalled result holds in the output register; the block does not advance
// any step that needs to emit until the register frees.
module date_keyed_entry_table import dket_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [15:0] year,
	input  logic [31:0] payload_handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] found_handle,
	output logic        last
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_LIST   = 5'b00100,
		S_DEL    = 5'b01000,
		S_FINAL  = 5'b10000
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;       // entries held
	logic [CW-1:0]  len_q;       // current ring length during a scan
	logic [CW-1:0]  scan_q;      // entries to visit in this scan
	logic [CW-1:0]  step_q;
	logic [NW-1:0]  nm_q;        // matches found by a list request
	logic           pend_q;      // a match is held back to learn its last flag
	logic           found_q;
	logic [31:0]    pend_h_q;
	logic [1:0]     req_q;
	entry_t         key_q;

	logic           out_vld_q;
	logic [2:0]     out_st_q;
	logic [31:0]    out_h_q;
	logic           out_last_q;

	entry_t         cell_q [CAPACITY];
	entry_t         head;
	logic           key_hit, list_hit, emit_ok, last_step;
	logic           adv, drop, load_en, emit, e_last;
	logic [2:0]     e_st;
	logic [31:0]    e_h;
	logic           in_take;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign head     = cell_q[0];
	assign emit_ok  = !out_vld_q || !out_stall;

	// compare the head cell against the key; list stops counting at its limit
	assign key_hit   = (head.day == key_q.day) && (head.month == key_q.month) &&
			(head.year == key_q.year);
	assign list_hit  = key_hit && (nm_q != NW'(MAX_OUT));
	assign last_step = ((step_q + CW'(1)) == scan_q);

	always_comb begin
		adv     = 1'b0;
		drop    = 1'b0;
		load_en = 1'b0;
		emit    = 1'b0;
		e_st    = ST_ADDED;
		e_h     = '0;
		e_last  = 1'b1;
		case (state_q)
			S_DECODE: begin
				if (req_q == REQ_ADD && emit_ok) begin
					emit = 1'b1;
					if (!date_ok(key_q.day, key_q.month, key_q.year)) begin
						e_st = ST_INVALID;
					end else if (cnt_q == CW'(CAPACITY)) begin
						e_st = ST_FULL;
					end else begin
						load_en = 1'b1;
					end
				end
			end
			S_LIST: begin
				// a second match pushes the held one out with last low
				adv = !(list_hit && pend_q) || emit_ok;
				if (adv && list_hit && pend_q) begin
					emit   = 1'b1;
					e_st   = ST_MATCH;
					e_h    = pend_h_q;
					e_last = 1'b0;
				end
			end
			S_DEL: begin
				adv  = 1'b1;
				drop = key_hit && !found_q;
			end
			S_FINAL: begin
				if (emit_ok) begin
					emit = 1'b1;
					if (req_q == REQ_LIST) begin
						e_st = pend_q ? ST_MATCH : ST_NOMATCH;
						e_h  = pend_q ? pend_h_q : 32'd0;
					end else begin
						e_st = found_q ? ST_DELETED : ST_NOMATCH;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// cell row: each cell moves toward the head, the tail of the ring takes the
	// head back unless the head is being dropped, and an add loads cell cnt_q
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t ctl;
		entry_t    nxt;

		assign ctl.shift = adv && (CW'(i + 1) < len_q);
		assign ctl.wrap  = adv && !drop && (CW'(i + 1) == len_q);
		assign ctl.load  = load_en && (CW'(i) == cnt_q);

		if (i == CAPACITY - 1) begin : g_tail
			assign nxt = head;
		end else begin : g_mid
			assign nxt = cell_q[i + 1];
		end

		dket_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.nxt_e  (nxt),
			.head_e (head),
			.load_e (key_q),
			.ent    (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			len_q     <= '0;
			scan_q    <= '0;
			step_q    <= '0;
			nm_q      <= '0;
			pend_q    <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (req_q == REQ_ADD) begin
						if (emit_ok) begin
							if (load_en) begin
								cnt_q <= cnt_q + CW'(1);
							end
							state_q <= S_IDLE;
						end
					end else if (req_q inside {REQ_LIST, REQ_DEL}) begin
						step_q  <= '0;
						len_q   <= cnt_q;
						scan_q  <= cnt_q;
						nm_q    <= '0;
						pend_q  <= 1'b0;
						found_q <= 1'b0;
						if (cnt_q == '0) begin
							state_q <= S_FINAL;
						end else if (req_q == REQ_LIST) begin
							state_q <= S_LIST;
						end else begin
							state_q <= S_DEL;
						end
					end else begin
						// unused request code: drop it silently
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (adv) begin
						step_q <= step_q + CW'(1);
						if (list_hit) begin
							pend_q <= 1'b1;
							nm_q   <= nm_q + NW'(1);
						end
						if (last_step) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_DEL: begin
					step_q <= step_q + CW'(1);
					if (drop) begin
						len_q   <= len_q - CW'(1);
						cnt_q   <= cnt_q - CW'(1);
						found_q <= 1'b1;
					end
					if (last_step) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (emit_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q        <= req_type;
			key_q.day    <= day;
			key_q.month  <= month;
			key_q.year   <= year;
			key_q.handle <= payload_handle;
		end
		if (state_q == S_LIST && adv && list_hit) begin
			pend_h_q <= head.handle;
		end
		if (emit) begin
			out_st_q   <= e_st;
			out_h_q    <= e_h;
			out_last_q <= e_last;
		end
	end

	assign out_valid    = out_vld_q;
	assign status       = out_st_q;
	assign found_handle = out_h_q;
	assign last         = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_MATCH) |-> (found_handle == 32'd0))
		else $error("nonzero handle on a result that is not a match");

	a_del_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL) |=> ((cnt_q == $past(cnt_q)) ||
			(cnt_q == $past(cnt_q) - CW'(1))))
		else $error("delete removed more than one entry");

	a_len_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= cnt_q)
		else $error("scan ring longer than the table");

endmodule

// File: tb/sv/entry_table_checker.sv
`timescale 1ns / 100ps
// Result checker for the date-keyed entry table: mirrors the table and compares every result.
module entry_table_checker import dket_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [15:0] year,
	input  logic [31:0] payload_handle,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [31:0] found_handle,
	input  logic        last,
	output int          mismatches,
	output int          results_due
);

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] handle;
		logic        last;
	} result_t;

	localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	entry_t  entry_mirror [DEPTH];
	int      fill;
	result_t pending_results [$];
	result_t want;

	function automatic logic leap_year(input logic [15:0] y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic logic valid_date(input logic [4:0] d, input logic [3:0] m,
			input logic [15:0] y);
		logic [4:0] limit;
		if (m < 4'd1 || m > 4'd12)
			return 1'b0;
		limit = (m == 4'd2 && leap_year(y)) ? 5'd29 : MONTH_LEN[m - 4'd1];
		return d >= 5'd1 && d <= limit;
	endfunction

	function automatic void queue_result(input logic [2:0] st, input logic [31:0] h,
			input logic fin);
		result_t r;
		r.status = st;
		r.handle = h;
		r.last = fin;
		pending_results.push_back(r);
	endfunction

	// Advance the mirror by one request and queue what it must produce.
	function automatic void apply_request(input logic [1:0] kind, input logic [4:0] d,
			input logic [3:0] m, input logic [15:0] y, input logic [31:0] h);
		int total;
		int sent;
		int hit;
		total = 0;
		sent = 0;
		hit = -1;
		case (kind)
			REQ_ADD: begin
				if (!valid_date(d, m, y)) begin
					queue_result(ST_INVALID, '0, 1'b1);
				end else if (fill >= DEPTH) begin
					queue_result(ST_FULL, '0, 1'b1);
				end else begin
					entry_mirror[fill] = '{day: d, month: m, year: y, handle: h};
					fill++;
					queue_result(ST_ADDED, '0, 1'b1);
				end
			end
			REQ_LIST: begin
				for (int i = 0; i < fill; i++)
					if (entry_mirror[i].day == d && entry_mirror[i].month == m &&
							entry_mirror[i].year == y && total < MAX_OUT)
						total++;
				if (total == 0)
					queue_result(ST_NOMATCH, '0, 1'b1);
				for (int i = 0; i < fill && sent < total; i++)
					if (entry_mirror[i].day == d && entry_mirror[i].month == m &&
							entry_mirror[i].year == y) begin
						sent++;
						queue_result(ST_MATCH, entry_mirror[i].handle, sent == total);
					end
			end
			REQ_DEL: begin
				for (int i = 0; i < fill && hit < 0; i++)
					if (entry_mirror[i].day == d && entry_mirror[i].month == m &&
							entry_mirror[i].year == y)
						hit = i;
				if (hit < 0) begin
					queue_result(ST_NOMATCH, '0, 1'b1);
				end else begin
					for (int j = hit; j + 1 < fill; j++)
						entry_mirror[j] = entry_mirror[j + 1];
					fill--;
					queue_result(ST_DELETED, '0, 1'b1);
				end
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			pending_results.delete();
			mismatches = 0;
			results_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: status %0d found_handle %h last %0b",
						status, found_handle, last);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						mismatches++;
					end
					if (found_handle !== want.handle) begin
						$error("found_handle: expected %h, actual %h", want.handle,
							found_handle);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, last);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				apply_request(req_type, day, month, year, payload_handle);
			results_due <= pending_results.size();
		end
	end

endmodule

// File: tb/sv/date_keyed_entry_table_tb.sv
`timescale 1ns / 100ps
// Top of the date-keyed entry table testbench: clock, reset, request stimulus and verdict.
module date_keyed_entry_table_tb import dket_pkg::*;;

	localparam int TABLE_DEPTH = 64;
	// request code the block must ignore
	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam int KEY_COUNT = 6;
	localparam int PHASE_ITEMS = 146;
	// receiver hold-off, long enough to back the block up into its input
	localparam int LONG_HOLD = 400;
	// a full scan plus setup, with margin
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
	} date_key_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [4:0]  day;
	logic [3:0]  month;
	logic [15:0] year;
	logic [31:0] payload_handle;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [31:0] found_handle;
	logic        last;

	int          mismatches;
	int          results_due;

	// idle percentages per side; the receiver's is read at the clock edge
	int          send_idle_pct = 35;
	int          recv_idle_pct = 82;
	// toggling hold_flip asks the receiver for one long hold-off
	logic        hold_flip = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;

	// small pool of dates so that lists and deletes find matches
	date_key_t   date_keys [KEY_COUNT];

	date_keyed_entry_table #(.CAPACITY(TABLE_DEPTH)) u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .day, .month, .year,
		.payload_handle, .out_valid, .out_stall, .status, .found_handle, .last
	);

	entry_table_checker #(.DEPTH(TABLE_DEPTH)) u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .day, .month, .year,
		.payload_handle, .out_valid, .out_stall, .status, .found_handle, .last,
		.mismatches, .results_due
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: random stalls, or a counted long hold-off when asked.
	always @(posedge clk) begin
		if (hold_seen != hold_flip) begin
			hold_seen <= hold_flip;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Offer one request after a random gap; hold it until the block takes it.
	task automatic send_request(input logic [1:0] kind, input logic [4:0] d,
			input logic [3:0] m, input logic [15:0] y, input logic [31:0] h);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		day <= d;
		month <= m;
		year <= y;
		payload_handle <= h;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every expected result has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	// One random request. Most use a pooled date; a few are pure noise or
	// adds with a broken date. add_pct and del_pct shape the table's fill.
	task automatic random_request(input int add_pct, input int del_pct);
		int          pick;
		int          k;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [15:0] y;
		logic [31:0] h;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, KEY_COUNT - 1);
		d = date_keys[k].day;
		m = date_keys[k].month;
		y = date_keys[k].year;
		h = $urandom;
		if (pick < 4) begin
			// noise: any code, any key, including the ignored code
			send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
				4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)), h);
		end else if (pick < 4 + add_pct) begin
			case ($urandom_range(0, 9))
				0: begin
					d = 5'($urandom_range(1, 28));
					m = 4'($urandom_range(1, 12));
					y = 16'($urandom_range(0, 65535));
				end
				1: begin
					// break the date: bad month, day zero, day past month end
					case ($urandom_range(0, 3))
						0: m = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(13, 15));
						1: d = 5'd0;
						2: begin
							d = 5'd31;
							case ($urandom_range(0, 4))
								0: m = 4'd2;
								1: m = 4'd4;
								2: m = 4'd6;
								3: m = 4'd9;
								default: m = 4'd11;
							endcase
						end
						default: begin
							d = 5'($urandom_range(29, 31));
							m = 4'd2;
						end
					endcase
				end
				default: begin
				end
			endcase
			send_request(REQ_ADD, d, m, y, h);
		end else begin
			// keys on list and delete are compared raw, so stray ones are fair game
			if ($urandom_range(0, 6) == 0) begin
				d = 5'($urandom_range(0, 31));
				m = 4'($urandom_range(0, 15));
				y = 16'($urandom_range(0, 65535));
			end
			if ($urandom_range(0, 99) < del_pct)
				send_request(REQ_DEL, d, m, y, h);
			else
				send_request(REQ_LIST, d, m, y, h);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_ADD;
		day = '0;
		month = '0;
		year = '0;
		payload_handle = '0;

		date_keys[0] = '{5'd29, 4'd2, 16'd2000};
		date_keys[1] = '{5'd31, 4'd12, 16'd65535};
		for (int i = 2; i < KEY_COUNT; i++)
			date_keys[i] = '{5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)),
				16'($urandom_range(0, 65535))};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: date corners, every request code, empty-table lookups.
		send_request(REQ_LIST, 5'd1, 4'd1, 16'd0, 32'h0);
		send_request(REQ_DEL, 5'd1, 4'd1, 16'd0, 32'h0);
		send_request(REQ_ADD, 5'd1, 4'd1, 16'd0, 32'h0000_0000);
		// year zero is a leap year
		send_request(REQ_ADD, 5'd29, 4'd2, 16'd0, 32'hFFFF_FFFF);
		// century not divisible by 400 is not
		send_request(REQ_ADD, 5'd29, 4'd2, 16'd1900, 32'h1111_1111);
		send_request(REQ_ADD, 5'd29, 4'd2, 16'd2000, 32'h2222_2222);
		send_request(REQ_ADD, 5'd29, 4'd2, 16'd2024, 32'h3333_3333);
		send_request(REQ_ADD, 5'd29, 4'd2, 16'd2023, 32'h4444_4444);
		send_request(REQ_ADD, 5'd31, 4'd12, 16'd65535, 32'hA5A5_5A5A);
		send_request(REQ_ADD, 5'd31, 4'd4, 16'd2021, 32'h5555_5555);
		send_request(REQ_ADD, 5'd0, 4'd5, 16'd2021, 32'h6666_6666);
		send_request(REQ_ADD, 5'd1, 4'd0, 16'd2021, 32'h7777_7777);
		send_request(REQ_ADD, 5'd1, 4'd13, 16'd2021, 32'h8888_8888);
		send_request(REQ_ADD, 5'd31, 4'd15, 16'd65535, 32'h9999_9999);
		send_request(REQ_ADD, 5'd1, 4'd1, 16'd0, 32'h1234_5678);
		send_request(REQ_LIST, 5'd1, 4'd1, 16'd0, 32'h0);
		send_request(REQ_LIST, 5'd2, 4'd2, 16'd2, 32'h0);
		send_request(REQ_LIST, 5'd0, 4'd0, 16'd0, 32'h0);
		send_request(REQ_DEL, 5'd1, 4'd1, 16'd0, 32'h0);
		send_request(REQ_LIST, 5'd1, 4'd1, 16'd0, 32'h0);
		send_request(REQ_DEL, 5'd3, 4'd3, 16'd3, 32'h0);
		send_request(REQ_IGNORED, 5'd31, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(REQ_DEL, 5'd31, 4'd12, 16'd65535, 32'h0);
		send_request(REQ_LIST, 5'd29, 4'd2, 16'd0, 32'h0);
		wait_for_results();

		// Slow receiver, add-heavy: fill the table and run into full.
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_request(80, 30);
		wait_for_results();

		// Slow sender, delete-heavy: drain the table back down.
		send_idle_pct = 82;
		recv_idle_pct <= 35;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_request(20, 60);
		wait_for_results();

		// No idling; open with a long receiver hold-off so requests back up.
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_flip <= ~hold_flip;
		for (int i = 0; i < PHASE_ITEMS; i++)
			random_request(45, 40);
		wait_for_results();
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
